[sv/int8_outer_product_tile_accumulator_assert.svh]
// ----------------------------------------------------------------------------
// int8_outer_product_tile_accumulator assertion macros
// Concurrent check helpers for the tile accumulator, removed under SYNTH.
// ----------------------------------------------------------------------------
`ifndef INT8_OUTER_PRODUCT_TILE_ACCUMULATOR_ASSERT_SVH
`define INT8_OUTER_PRODUCT_TILE_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTH
`define OPTA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("opta assertion failed");
`define OPTA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("opta assertion failed");
`else
`define OPTA_ASSERT_SAME(label, clk, rst, ante, cons)
`define OPTA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/opta_pkg.sv]
// ----------------------------------------------------------------------------
// opta_pkg
// Shared types and constants of the int8 outer product tile accumulator.
// ----------------------------------------------------------------------------
package opta_pkg;

   localparam int TILE_DIM_DEF   = 16;
   localparam int TILE_COUNT_DEF = 4;
   localparam int LANES          = 8;
   localparam int SUMS           = 4;
   localparam int ACC_W          = 32;
   localparam int ADDR_W         = 6;
   localparam int QUAD_W         = 2;
   localparam int CNT_W          = 8;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_A_WORD = 2'd1,
      OP_B_WORD = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_READ
   } state_type;

   typedef struct packed {
      logic             capture;
      logic             clear_wr;
      logic             upd_wr;
      logic             rsp_load;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   b_ok;
      logic   rsp_busy;
   } sts_type;

endpackage

[sv/opta_ram.sv]
// ----------------------------------------------------------------------------
// opta_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module opta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/opta_ctrl.sv]
// ----------------------------------------------------------------------------
// opta_ctrl
// Sequencer: clearing sweep, item decode, row update loop and read hand-off.
// ----------------------------------------------------------------------------
module opta_ctrl #(
   parameter int TILE_DIM   = opta_pkg::TILE_DIM_DEF,
   parameter int BLOCK_ROWS = opta_pkg::TILE_DIM_DEF * opta_pkg::TILE_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  opta_pkg::sts_type sts,
   output opta_pkg::cmd_type cmd
);
   import opta_pkg::*;

   localparam logic [CNT_W-1:0] UPD_LAST = CNT_W'(TILE_DIM - 1);
   localparam logic [CNT_W-1:0] CLR_LAST = CNT_W'(BLOCK_ROWS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cnt_in = '0;
            unique case (sts.op)
               OP_CLEAR:  state_in = ST_CLEAR;
               OP_A_WORD: state_in = ST_IDLE;
               OP_B_WORD: state_in = sts.b_ok ? ST_UPD_RD : ST_IDLE;
               OP_READ:   state_in = ST_READ;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff == UPD_LAST) ? ST_IDLE : ST_UPD_RD;
         end
         ST_READ: begin
            if (!sts.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.cnt   = cnt_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_wr = 1'b1;
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_DECODE: ;
         ST_UPD_RD: ;
         ST_UPD_WR: cmd.upd_wr = 1'b1;
         ST_READ:   cmd.rsp_load = !sts.rsp_busy;
         default:   ;
      endcase
   end

endmodule

[sv/opta_dp.sv]
// ----------------------------------------------------------------------------
// opta_dp
// Datapath: request latch, A buffer, dot product lanes, accumulator rows and
// the result register.
// ----------------------------------------------------------------------------
module opta_dp #(
   parameter int TILE_DIM   = opta_pkg::TILE_DIM_DEF,
   parameter int TILE_COUNT = opta_pkg::TILE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_op,
   input  logic [opta_pkg::ADDR_W-1:0]       req_addr,
   input  logic [opta_pkg::QUAD_W-1:0]       req_quad,
   input  logic signed [7:0]                 req_lane [opta_pkg::LANES],
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [opta_pkg::ACC_W-1:0] rsp_sum [opta_pkg::SUMS],
   input  opta_pkg::cmd_type                 cmd,
   output opta_pkg::sts_type                 sts
);
   import opta_pkg::*;

   localparam int A_WORDS    = TILE_DIM / 2;
   localparam int BW         = TILE_DIM / 2;
   localparam int BLOCK_ROWS = TILE_COUNT * TILE_DIM;
   localparam int RA_W       = $clog2(BLOCK_ROWS);
   localparam int ROW_BITS   = TILE_DIM * ACC_W;

   op_type                  op_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [QUAD_W-1:0]       quad_ff;
   logic signed [7:0]       lane_ff [LANES];
   logic [63:0]             a_ff [A_WORDS];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0] rsp_sum_ff [SUMS];
   logic signed [ACC_W-1:0] rsp_sum_in [SUMS];

   logic [1:0]              tile;
   logic [CNT_W-1:0]        base, cidx, c0, upd_row, row_sel;
   logic [ROW_BITS-1:0]     rd_data, wr_data;
   logic [ACC_W-1:0]        acc_rd [TILE_DIM];
   logic [ACC_W-1:0]        acc_wr [TILE_DIM];
   logic [63:0]             a_word;
   logic [31:0]             a_half;
   logic signed [15:0]      prod0 [4];
   logic signed [15:0]      prod1 [4];
   logic signed [17:0]      dot0, dot1;
   logic                    row_ok;
   logic [5:0]              col;
   logic                    we;
   logic [RA_W-1:0]         waddr;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_op);
         addr_ff <= req_addr;
         quad_ff <= req_quad;
         lane_ff <= req_lane;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < A_WORDS; w++) begin
            a_ff[w] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.capture && op_type'(req_op) == OP_A_WORD) begin
            for (int w = 0; w < A_WORDS; w++) begin
               if (CNT_W'(req_addr) == CNT_W'(w)) begin
                  a_ff[w] <= {req_lane[7], req_lane[6], req_lane[5], req_lane[4],
                              req_lane[3], req_lane[2], req_lane[1], req_lane[0]};
               end
            end
         end
      end
   end

   always_comb begin
      tile = '0;
      for (int t = 1; t < TILE_COUNT; t++) begin
         if (CNT_W'(addr_ff) >= CNT_W'(t * BW)) begin
            tile = 2'(t);
         end
      end
      base    = CNT_W'(tile) * CNT_W'(TILE_DIM);
      cidx    = CNT_W'(addr_ff) - CNT_W'(tile) * CNT_W'(BW);
      c0      = {cidx[CNT_W-2:0], 1'b0};
      upd_row = base + cmd.cnt;
      row_sel = (op_ff == OP_READ) ? CNT_W'(addr_ff) : upd_row;
   end

   assign sts.op       = op_ff;
   assign sts.b_ok     = CNT_W'(addr_ff) < CNT_W'(TILE_COUNT * BW);
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      a_word = '0;
      for (int w = 0; w < A_WORDS; w++) begin
         if (CNT_W'(w) == (cmd.cnt >> 1)) begin
            a_word = a_ff[w];
         end
      end
      a_half = cmd.cnt[0] ? a_word[63:32] : a_word[31:0];
      for (int k = 0; k < 4; k++) begin
         prod0[k] = $signed(a_half[8*k +: 8]) * lane_ff[k];
         prod1[k] = $signed(a_half[8*k +: 8]) * lane_ff[4+k];
      end
      dot0 = 18'(prod0[0]) + 18'(prod0[1]) + 18'(prod0[2]) + 18'(prod0[3]);
      dot1 = 18'(prod1[0]) + 18'(prod1[1]) + 18'(prod1[2]) + 18'(prod1[3]);
   end

   always_comb begin
      for (int c = 0; c < TILE_DIM; c++) begin
         acc_rd[c] = rd_data[c*ACC_W +: ACC_W];
         acc_wr[c] = acc_rd[c];
         if (CNT_W'(c) == c0) begin
            acc_wr[c] = acc_rd[c] + ACC_W'(dot0);
         end
         if (CNT_W'(c) == c0 + 1'b1) begin
            acc_wr[c] = acc_rd[c] + ACC_W'(dot1);
         end
         wr_data[c*ACC_W +: ACC_W] = cmd.clear_wr ? '0 : acc_wr[c];
      end
   end

   assign we    = cmd.clear_wr || cmd.upd_wr;
   assign waddr = cmd.clear_wr ? cmd.cnt[RA_W-1:0] : upd_row[RA_W-1:0];

   opta_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (BLOCK_ROWS)
   ) u_acc_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wr_data),
      .raddr (row_sel[RA_W-1:0]),
      .rdata (rd_data)
   );

   always_comb begin
      row_ok = CNT_W'(addr_ff) < CNT_W'(BLOCK_ROWS);
      col    = '0;
      for (int n = 0; n < SUMS; n++) begin
         col           = {2'b00, quad_ff, 2'(n)};
         rsp_sum_in[n] = cmd.rsp_load ? '0 : rsp_sum_ff[n];
         if (cmd.rsp_load && row_ok) begin
            for (int c = 0; c < TILE_DIM; c++) begin
               if (6'(c) == col) begin
                  rsp_sum_in[n] = acc_rd[c];
               end
            end
         end
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;

endmodule

[sv/int8_outer_product_tile_accumulator.sv]
// ----------------------------------------------------------------------------
// int8_outer_product_tile_accumulator
// Signed int8 outer product accumulation into a block of 32-bit sums.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  op, addr, quad, lane0..lane7
//  rsp       out        rsp_valid/rsp_stall  sum0..sum3 (reads only)
//
//  A B word does one read and one write of the single accumulator RAM port
//  pair per tile row.
//  After reset, a clearing pass over all accumulator rows holds req_stall.
//  A read waits while a previous result is stalled in the output register.
// ----------------------------------------------------------------------------
`include "int8_outer_product_tile_accumulator_assert.svh"

module int8_outer_product_tile_accumulator #(
   parameter int TILE_DIM   = opta_pkg::TILE_DIM_DEF,
   parameter int TILE_COUNT = opta_pkg::TILE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [opta_pkg::ADDR_W-1:0]       req_addr,
   input  logic [opta_pkg::QUAD_W-1:0]       req_quad,
   input  logic signed [7:0]                 req_lane0,
   input  logic signed [7:0]                 req_lane1,
   input  logic signed [7:0]                 req_lane2,
   input  logic signed [7:0]                 req_lane3,
   input  logic signed [7:0]                 req_lane4,
   input  logic signed [7:0]                 req_lane5,
   input  logic signed [7:0]                 req_lane6,
   input  logic signed [7:0]                 req_lane7,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [opta_pkg::ACC_W-1:0] rsp_sum0,
   output logic signed [opta_pkg::ACC_W-1:0] rsp_sum1,
   output logic signed [opta_pkg::ACC_W-1:0] rsp_sum2,
   output logic signed [opta_pkg::ACC_W-1:0] rsp_sum3
);
   import opta_pkg::*;

   cmd_type                 cmd;
   sts_type                 sts;
   logic signed [7:0]       lanes [LANES];
   logic signed [ACC_W-1:0] sums [SUMS];

   assign lanes[0] = req_lane0;
   assign lanes[1] = req_lane1;
   assign lanes[2] = req_lane2;
   assign lanes[3] = req_lane3;
   assign lanes[4] = req_lane4;
   assign lanes[5] = req_lane5;
   assign lanes[6] = req_lane6;
   assign lanes[7] = req_lane7;

   opta_ctrl #(
      .TILE_DIM   (TILE_DIM),
      .BLOCK_ROWS (TILE_COUNT * TILE_DIM)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   opta_dp #(
      .TILE_DIM   (TILE_DIM),
      .TILE_COUNT (TILE_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_op),
      .req_addr  (req_addr),
      .req_quad  (req_quad),
      .req_lane  (lanes),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_sum   (sums),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign rsp_sum0 = sums[0];
   assign rsp_sum1 = sums[1];
   assign rsp_sum2 = sums[2];
   assign rsp_sum3 = sums[3];

   `OPTA_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `OPTA_ASSERT_SAME(a_idle_no_write, clock, reset, !req_stall, !cmd.clear_wr && !cmd.upd_wr)
   `OPTA_ASSERT_SAME(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

[verif/tb_int8_outer_product_tile_accumulator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_int8_outer_product_tile_accumulator
// Drives directed and random A, B, clear and read beats into the tile
// accumulator, predicts each read from an own model of the A buffer and
// accumulator block or fixed sums, checks each result beat field by field.
// ----------------------------------------------------------------------------
module tb_int8_outer_product_tile_accumulator;
   import opta_pkg::*;

   localparam int  N_ITEMS   = 1500;
   localparam int  ROWS      = 64;
   localparam int  COLS      = 16;
   localparam int  A_WORDS   = 8;
   localparam int  B_WORDS   = 32;
   localparam int  SETTLE    = 80;
   localparam int  HOLD_LEN  = 400;
   localparam longint LIMIT  = 2000000;

   typedef logic [3:0][31:0] sums_type;

   typedef struct packed {
      op_type          op;
      logic [5:0]      addr;
      logic [1:0]      quad;
      logic [7:0][7:0] lanes;
   } beat_type;

   typedef struct packed {
      beat_type b;
      logic     typed;
      sums_type sums;
   } row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_op;
   logic [5:0] req_addr;
   logic [1:0] req_quad;
   logic signed [7:0] req_lane0, req_lane1, req_lane2, req_lane3;
   logic signed [7:0] req_lane4, req_lane5, req_lane6, req_lane7;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_sum0, rsp_sum1, rsp_sum2, rsp_sum3;

   logic [7:0][7:0] a_words [A_WORDS];
   logic [31:0]     acc_mem [ROWS*COLS];
   sums_type        pending_sums[$];
   int              errors = 0;
   int              sent = 0;
   int              phase = 0;
   longint          cycles = 0;
   int              hold_left = 0;
   bit              hold_done = 0;

   int8_outer_product_tile_accumulator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_addr(req_addr), .req_quad(req_quad),
      .req_lane0(req_lane0), .req_lane1(req_lane1), .req_lane2(req_lane2),
      .req_lane3(req_lane3), .req_lane4(req_lane4), .req_lane5(req_lane5),
      .req_lane6(req_lane6), .req_lane7(req_lane7),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sum0(rsp_sum0), .rsp_sum1(rsp_sum1),
      .rsp_sum2(rsp_sum2), .rsp_sum3(rsp_sum3)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   function automatic bit accumulate_beat(input beat_type b, output sums_type sums);
      int dot;
      int base;
      sums = '0;
      accumulate_beat = 1'b0;
      case (b.op)
         OP_CLEAR: begin
            foreach (acc_mem[i]) acc_mem[i] = '0;
         end
         OP_A_WORD: begin
            if (b.addr < A_WORDS) a_words[b.addr] = b.lanes;
         end
         OP_B_WORD: begin
            if (b.addr < B_WORDS) begin
               base = (b.addr / 8) * COLS * COLS + (b.addr % 8) * 2;
               for (int r = 0; r < COLS; r++) begin
                  for (int j = 0; j < 2; j++) begin
                     dot = 0;
                     for (int k = 0; k < 4; k++)
                        dot += int'($signed(a_words[r/2][(r%2)*4+k]))
                             * int'($signed(b.lanes[4*j+k]));
                     acc_mem[base + r*COLS + j] += dot;
                  end
               end
            end
         end
         default: begin
            for (int n = 0; n < 4; n++)
               sums[n] = acc_mem[b.addr*COLS + b.quad*4 + n];
            accumulate_beat = 1'b1;
         end
      endcase
   endfunction

   function automatic row_type mk(op_type op, int addr, int quad, logic [7:0] fill,
                                  logic typed = 0, sums_type sums = '0);
      row_type r;
      r.b.op = op;
      r.b.addr = addr[5:0];
      r.b.quad = quad[1:0];
      r.b.lanes = {8{fill}};
      r.typed = typed;
      r.sums = sums;
      return r;
   endfunction

   function automatic beat_type rand_beat(op_type op, int addr, int quad);
      beat_type b;
      b.op = op;
      b.addr = addr[5:0];
      b.quad = quad[1:0];
      for (int n = 0; n < 8; n++) b.lanes[n] = 8'($urandom);
      return b;
   endfunction

   task automatic send_beat(input row_type r);
      sums_type sums;
      if (phase < 2 && $urandom_range(99) < (phase == 0 ? 20 : 65)) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= r.b.op;
      req_addr  <= r.b.addr;
      req_quad  <= r.b.quad;
      req_lane0 <= r.b.lanes[0];
      req_lane1 <= r.b.lanes[1];
      req_lane2 <= r.b.lanes[2];
      req_lane3 <= r.b.lanes[3];
      req_lane4 <= r.b.lanes[4];
      req_lane5 <= r.b.lanes[5];
      req_lane6 <= r.b.lanes[6];
      req_lane7 <= r.b.lanes[7];
      do @(posedge clock); while (req_stall);
      if (accumulate_beat(r.b, sums))
         pending_sums.push_back(r.typed ? r.sums : sums);
      sent++;
      phase = sent < N_ITEMS/3 ? 0 : (sent < 2*N_ITEMS/3 ? 1 : 2);
   endtask

   always @(posedge clock) begin
      sums_type got, want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_sum3, rsp_sum2, rsp_sum1, rsp_sum0};
            if (pending_sums.size() == 0) begin
               $display("%0t: unexpected result beat, actual %h", $time, got);
               errors++;
            end else begin
               want = pending_sums.pop_front();
               for (int n = 0; n < 4; n++)
                  if (got[n] !== want[n]) begin
                     $display("%0t: sum%0d expected %0d actual %0d", $time, n,
                              $signed(want[n]), $signed(got[n]));
                     errors++;
                  end
            end
         end
         if (!hold_done && sent >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= phase < 2 && $urandom_range(99) < (phase == 0 ? 65 : 20);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[int8_outer_product_tile_accumulator] ERROR");
         $finish;
      end
   end

   initial begin
      row_type directed[$];
      int      nb, nr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_CLEAR;
      req_addr = '0;
      req_quad = '0;
      {req_lane0, req_lane1, req_lane2, req_lane3} = '0;
      {req_lane4, req_lane5, req_lane6, req_lane7} = '0;
      rsp_stall = 1'b0;
      foreach (a_words[i]) a_words[i] = '0;
      foreach (acc_mem[i]) acc_mem[i] = '0;

      directed.push_back(mk(OP_READ, 0, 0, 8'h00, 1, '0));
      directed.push_back(mk(OP_A_WORD, 0, 0, 8'h80));
      directed.push_back(mk(OP_A_WORD, 7, 0, 8'h7f));
      directed.push_back(mk(OP_A_WORD, 63, 0, 8'h01));
      directed.push_back(mk(OP_B_WORD, 0, 0, 8'h80));
      directed.push_back(mk(OP_READ, 0, 0, 8'h00, 1, {32'd0, 32'd0, 32'd65536, 32'd65536}));
      directed.push_back(mk(OP_READ, 15, 0, 8'h00, 1,
                            {32'd0, 32'd0, -32'sd65024, -32'sd65024}));
      directed.push_back(mk(OP_B_WORD, 63, 0, 8'h7f));
      directed.push_back(mk(OP_B_WORD, 31, 0, 8'h7f));
      directed.push_back(mk(OP_READ, 48, 3, 8'hff, 1,
                            {-32'sd65024, -32'sd65024, 32'd0, 32'd0}));
      directed.push_back(mk(OP_READ, 63, 3, 8'h00, 1, {32'd64516, 32'd64516, 32'd0, 32'd0}));
      directed.push_back(mk(OP_READ, 1, 2, 8'h00));
      directed.push_back(mk(OP_CLEAR, 0, 0, 8'hff));
      directed.push_back(mk(OP_READ, 0, 0, 8'h00, 1, '0));
      directed.push_back(mk(OP_READ, 63, 3, 8'h00, 1, '0));
      directed.push_back(mk(OP_A_WORD, 3, 0, 8'h5a));
      directed.push_back(mk(OP_B_WORD, 9, 0, 8'ha5));
      directed.push_back(mk(OP_READ, 22, 1, 8'h00));
      directed.push_back(mk(OP_READ, 22, 0, 8'h00));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_beat(directed[i]);

      while (sent < N_ITEMS) begin
         row_type r;
         r.typed = 1'b0;
         r.sums = '0;
         case ($urandom_range(19))
            0: begin
               r.b = rand_beat(OP_CLEAR, $urandom_range(63), $urandom_range(3));
               send_beat(r);
            end
            1, 2: begin
               r.b = rand_beat(op_type'($urandom_range(3)), $urandom_range(63),
                               $urandom_range(3));
               send_beat(r);
            end
            default: begin
               for (int w = 0; w < A_WORDS; w++) begin
                  if ($urandom_range(7) != 0) begin
                     r.b = rand_beat(OP_A_WORD, w, $urandom_range(3));
                     send_beat(r);
                  end
               end
               nb = $urandom_range(6, 1);
               for (int i = 0; i < nb; i++) begin
                  r.b = rand_beat(OP_B_WORD, $urandom_range(B_WORDS-1), $urandom_range(3));
                  send_beat(r);
               end
               nr = $urandom_range(4, 1);
               for (int i = 0; i < nr; i++) begin
                  r.b = rand_beat(OP_READ, $urandom_range(ROWS-1), $urandom_range(3));
                  send_beat(r);
               end
            end
         endcase
      end

      req_valid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0)
         $display("[int8_outer_product_tile_accumulator] OK");
      else
         $display("[int8_outer_product_tile_accumulator] ERROR");
      $finish;
   end

endmodule
